### design/crfd_pkg.sv
// Shared constants, command codes and controller/datapath link types for the
// clipped rectangle framebuffer draw engine. No dependencies.
`default_nettype none

package crfd_pkg;

    localparam int MODE_W    = 2;
    localparam int COORD_W   = 11;
    localparam int SIZE_W    = 11;
    localparam int COLOR_W   = 8;
    // signed working width for corner + size sums and clip bounds
    localparam int CALC_W    = 13;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    localparam int DEF_SCREEN_WIDTH  = 97;
    localparam int DEF_SCREEN_HEIGHT = 75;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic load;    // capture the accepted command
        logic bound;   // compute clipped row/column range
        logic base;    // compute first row base address
        logic step;    // one pixel of the sweep
        logic result;  // load the output register
    } cmd_t;

    typedef struct packed {
        logic empty;   // nothing to sweep
        logic last;    // current pixel is the final one
    } status_t;

endpackage

`default_nettype wire

### design/crfd_ctrl.sv
// Controller state machine for the framebuffer draw engine.
// Depends on crfd_pkg for the command and status link types.
`default_nettype none

module crfd_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire               m_tready,
    output crfd_pkg::cmd_t    cmd,
    input  crfd_pkg::status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BOUND = 3'd1;
    localparam logic [2:0] ST_BASE  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load   = accept;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND: begin
                cmd.bound  = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                cmd.base   = 1'b1;
                state_next = status.empty ? ST_DONE : ST_SWEEP;
            end
            ST_SWEEP: begin
                cmd.step = 1'b1;
                if (status.last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.result) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_BOUND)
        else $error("accepted beat did not start bound calculation");

    a_empty_skips_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BASE && status.empty) |=> state_reg == ST_DONE)
        else $error("empty command entered the sweep");

    a_sweep_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && !status.last) |=> state_reg == ST_SWEEP)
        else $error("sweep ended before its last pixel");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result beat raised outside the done state");
`endif

endmodule

`default_nettype wire

### design/crfd_datapath.sv
// Datapath of the framebuffer draw engine: command registers, clip bounds,
// pixel sweep counters, the frame store and the result register. Uses crfd_pkg.
`default_nettype none

module crfd_datapath #(
    parameter int SCREEN_WIDTH  = crfd_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = crfd_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire                                  aclk,
    input  crfd_pkg::cmd_t                       cmd,
    output crfd_pkg::status_t                    status,
    input  wire [crfd_pkg::MODE_W-1:0]           mode,
    input  wire signed [crfd_pkg::COORD_W-1:0]   pos_x,
    input  wire signed [crfd_pkg::COORD_W-1:0]   pos_y,
    input  wire [crfd_pkg::SIZE_W-1:0]           rect_width,
    input  wire [crfd_pkg::SIZE_W-1:0]           rect_height,
    input  wire [crfd_pkg::COLOR_W-1:0]          pixel_color,
    input  wire                                  fill,
    output logic [crfd_pkg::COLOR_W-1:0]         read_color,
    output logic                                 off_screen
);

    localparam int CALC_W = crfd_pkg::CALC_W;
    localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW     = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int CW     = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;

    localparam logic signed [CALC_W-1:0] SW   = CALC_W'(SCREEN_WIDTH);
    localparam logic signed [CALC_W-1:0] SH   = CALC_W'(SCREEN_HEIGHT);
    localparam logic signed [CALC_W-1:0] ZERO = CALC_W'(0);
    localparam logic signed [CALC_W-1:0] ONE  = CALC_W'(1);

    // command registers
    logic [crfd_pkg::MODE_W-1:0]         mode_reg;
    logic signed [crfd_pkg::COORD_W-1:0] x0_reg;
    logic signed [crfd_pkg::COORD_W-1:0] y0_reg;
    logic [crfd_pkg::SIZE_W-1:0]         w_reg;
    logic [crfd_pkg::SIZE_W-1:0]         h_reg;
    logic [crfd_pkg::COLOR_W-1:0]        color_reg;
    logic                                fill_reg;

    // sweep state
    logic [RW-1:0]              row_reg, row_last_reg;
    logic [CW-1:0]              col_reg, col_first_reg, col_last_reg;
    logic signed [CALC_W-1:0]   ytop_reg, ybot_reg, xl_reg, xr_reg;
    logic                       solid_reg, write_reg, empty_reg, off_reg;
    logic [AW-1:0]              base_reg;

    logic [crfd_pkg::COLOR_W-1:0] mem [DEPTH];
    logic [crfd_pkg::COLOR_W-1:0] rd_data_reg;
    logic [crfd_pkg::COLOR_W-1:0] read_color_reg;
    logic                         off_screen_reg;

    logic signed [CALC_W-1:0] x0e, y0e, wext, hext, x_end, y_end;
    logic signed [CALC_W-1:0] r_lo, r_hi, c_lo, c_hi, r_last, c_last;
    logic signed [CALC_W-1:0] row_s, col_s;
    logic                     off_calc, empty_calc, is_read;
    logic                     edge_row, edge_col, we;
    logic [AW-1:0]            addr;

    assign x0e   = CALC_W'(x0_reg);
    assign y0e   = CALC_W'(y0_reg);
    assign wext  = CALC_W'(w_reg);
    assign hext  = CALC_W'(h_reg);
    assign x_end = x0e + wext;
    assign y_end = y0e + hext;

    assign is_read  = (mode_reg == crfd_pkg::MODE_READ);
    assign off_calc = x0e[CALC_W-1] || (x0e >= SW) || y0e[CALC_W-1] || (y0e >= SH);

    always_comb begin
        unique case (mode_reg)
            crfd_pkg::MODE_CLEAR: begin
                r_lo = ZERO;
                r_hi = SH;
                c_lo = ZERO;
                c_hi = SW;
            end
            crfd_pkg::MODE_RECT: begin
                r_lo = y0e[CALC_W-1] ? ZERO : y0e;
                r_hi = (y_end < SH) ? y_end : SH;
                c_lo = x0e[CALC_W-1] ? ZERO : x0e;
                c_hi = (x_end < SW) ? x_end : SW;
            end
            crfd_pkg::MODE_READ: begin
                r_lo = y0e;
                r_hi = y0e + ONE;
                c_lo = x0e;
                c_hi = x0e + ONE;
            end
            default: begin
                r_lo = ZERO;
                r_hi = ZERO;
                c_lo = ZERO;
                c_hi = ZERO;
            end
        endcase
    end

    assign r_last     = r_hi - ONE;
    assign c_last     = c_hi - ONE;
    assign empty_calc = (r_lo >= r_hi) || (c_lo >= c_hi) || (is_read && off_calc);

    // outline test uses the unclipped edges
    assign row_s    = CALC_W'(row_reg);
    assign col_s    = CALC_W'(col_reg);
    assign edge_row = (row_s == ytop_reg) || (row_s == ybot_reg);
    assign edge_col = (col_s == xl_reg) || (col_s == xr_reg);
    assign we       = cmd.step && write_reg && (solid_reg || edge_row || edge_col);
    assign addr     = base_reg + AW'(col_reg);

    assign status.empty = empty_reg;
    assign status.last  = (col_reg == col_last_reg) && (row_reg == row_last_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= mode;
            x0_reg    <= pos_x;
            y0_reg    <= pos_y;
            w_reg     <= rect_width;
            h_reg     <= rect_height;
            color_reg <= pixel_color;
            fill_reg  <= fill;
        end
        if (cmd.bound) begin
            row_reg       <= r_lo[RW-1:0];
            row_last_reg  <= r_last[RW-1:0];
            col_first_reg <= c_lo[CW-1:0];
            col_last_reg  <= c_last[CW-1:0];
            ytop_reg      <= y0e;
            ybot_reg      <= y_end - ONE;
            xl_reg        <= x0e;
            xr_reg        <= x_end - ONE;
            solid_reg     <= (mode_reg == crfd_pkg::MODE_CLEAR) || fill_reg;
            write_reg     <= (mode_reg == crfd_pkg::MODE_CLEAR) ||
                             (mode_reg == crfd_pkg::MODE_RECT);
            empty_reg     <= empty_calc;
            off_reg       <= is_read && off_calc;
        end
        if (cmd.base) begin
            base_reg <= AW'(row_reg * SCREEN_WIDTH);
            col_reg  <= col_first_reg;
        end else if (cmd.step) begin
            if (col_reg == col_last_reg) begin
                row_reg  <= row_reg + RW'(1);
                base_reg <= base_reg + AW'(SCREEN_WIDTH);
                col_reg  <= col_first_reg;
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
        if (cmd.result) begin
            read_color_reg <= (is_read && !off_reg) ? rd_data_reg : '0;
            off_screen_reg <= off_reg;
        end
    end

    // frame store: at most one write and one read per cycle, registered read data
    // read data is held after the sweep so a stalled output keeps the pixel
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= color_reg;
        end
        if (cmd.step) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign read_color = read_color_reg;
    assign off_screen = off_screen_reg;

endmodule

`default_nettype wire

### design/clipped_rectangle_framebuffer_draw.sv
// Framebuffer draw engine top level: clear, clipped rectangle fill/outline, pixel read.
// Flow: each accepted beat passes the bound and base states, then sweeps the clipped pixels
// (all SCREEN_WIDTH * SCREEN_HEIGHT for a clear, one for an on-screen read); an off-screen
// read, empty draw or unused mode skips the sweep; a stalled output adds its wait. One command
// at a time: the next beat is taken once the result sits in the output register. Reset
// (aresetn, synchronous, active low) clears control only. Uses crfd_pkg, crfd_ctrl, crfd_datapath.
`default_nettype none

module clipped_rectangle_framebuffer_draw #(
    parameter int SCREEN_WIDTH  = crfd_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = crfd_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // pos_x[10:0], pos_y[21:11], rect_width[32:22], rect_height[43:33],
    // pixel_color[51:44], zero [55:52]
    input  wire [crfd_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode[1:0], fill[2]
    input  wire [crfd_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // read_color[7:0]
    output logic [crfd_pkg::M_TDATA_W-1:0]   m_tdata,
    // off_screen[0]
    output logic [crfd_pkg::M_TUSER_W-1:0]   m_tuser
);

    crfd_pkg::cmd_t    cmd;
    crfd_pkg::status_t status;

    logic [crfd_pkg::COLOR_W-1:0] read_color;
    logic                         off_screen;

    crfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    crfd_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .aclk        (aclk),
        .cmd         (cmd),
        .status      (status),
        .mode        (s_tuser[1:0]),
        .pos_x       ($signed(s_tdata[10:0])),
        .pos_y       ($signed(s_tdata[21:11])),
        .rect_width  (s_tdata[32:22]),
        .rect_height (s_tdata[43:33]),
        .pixel_color (s_tdata[51:44]),
        .fill        (s_tuser[2]),
        .read_color  (read_color),
        .off_screen  (off_screen)
    );

    assign m_tdata = read_color;
    assign m_tuser = off_screen;

endmodule

`default_nettype wire
